### src/dst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_pkg: shared types and constants of the decision stump trainer
// payload structs, register indexes and the example store depth
// ----------------------------------------------------------------------------
package dst_pkg;

  localparam int unsigned MaxExamples = 1024;
  localparam int unsigned AddrW = $clog2(MaxExamples);
  localparam int unsigned CountW = $clog2(MaxExamples + 1);

  localparam logic RegSplitDim = 1'b0;
  localparam logic RegNumIter = 1'b1;

  typedef struct packed {
    logic        action;
    logic [19:0] feature_index;
    logic signed [31:0] feature_value;
    logic        label;
    logic        end_of_example;
    logic        end_of_set;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic        predicted_label;
    logic signed [31:0] threshold;
    logic        polarity;
    logic [10:0] error_count;
    logic        overflow;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic [CountW-1:0] count;
    logic [CountW-1:0] positives;
    logic [15:0] iter_cnt;
  } sweep_cmd_t;

  typedef struct packed {
    logic        done;
    logic signed [31:0] threshold;
    logic        polarity;
    logic [CountW-1:0] error;
  } sweep_res_t;

endpackage

### src/dst_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_divider: restoring divider for the sweep step
// one quotient bit per cycle, 33-bit unsigned dividend by 16-bit divisor
// ----------------------------------------------------------------------------
module dst_divider import dst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [32:0] dividend_i,
  input  logic [15:0] divisor_i,
  output logic        done_o,
  output logic [32:0] quotient_o
);

  logic [32:0] quo_q, quo_d;
  logic [16:0] rem_q, rem_d;
  logic [15:0] div_q, div_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [17:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    div_d = div_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial = {rem_q, quo_q[32]} - {2'b00, div_q};
    if (start_i) begin
      quo_d = dividend_i;
      rem_d = '0;
      div_d = divisor_i;
      cnt_d = 6'd33;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[31:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[32]};
        quo_d = {quo_q[31:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule

### src/dst_sweep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_sweep: example store and threshold sweep sequencer
// stores examples, scans for min/max, then counts errors per threshold
// ----------------------------------------------------------------------------
module dst_sweep import dst_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [AddrW-1:0]   wr_addr_i,
  input  logic signed [31:0] wr_value_i,
  input  logic               wr_label_i,
  input  sweep_cmd_t         cmd_i,
  output sweep_res_t         res_o
);

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SScan = 3'd1;
  localparam logic [2:0] SDiv  = 3'd2;
  localparam logic [2:0] SCnt  = 3'd3;
  localparam logic [2:0] SEval = 3'd4;
  localparam logic [2:0] SDone = 3'd5;

  logic signed [31:0] mem_val [MaxExamples];
  logic               mem_lbl [MaxExamples];
  logic signed [31:0] rd_val_q;
  logic               rd_lbl_q;

  logic [2:0]  state_q, state_d;
  logic [CountW-1:0] n_q, pos_q, idx_q, idx_d;
  logic [15:0] it_q;
  logic [15:0] k_q, k_d;
  logic        rd_v_q, rd_v_d;
  logic signed [31:0] lo_q, lo_d, hi_q, hi_d;
  logic signed [33:0] t_q, t_d;
  logic [32:0] step_q;
  logic [CountW-1:0] gp_q, gp_d, gn_q, gn_d;
  logic signed [31:0] best_t_q, best_t_d;
  logic        best_p_q, best_p_d;
  logic [CountW-1:0] err_q, err_d;
  logic        done_q, done_d;
  logic        div_start, div_done;
  logic [32:0] div_quo;
  logic [CountW-1:0] neg_cnt, lp, ln, ea, eb;
  logic [CountW:0] sa, sb;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_val[wr_addr_i] <= wr_value_i;
      mem_lbl[wr_addr_i] <= wr_label_i;
    end
    rd_val_q <= mem_val[idx_q[AddrW-1:0]];
    rd_lbl_q <= mem_lbl[idx_q[AddrW-1:0]];
  end

  dst_divider u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(33'(hi_q - lo_q)),
    .divisor_i (it_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    neg_cnt = n_q - pos_q;
    lp = pos_q - gp_q;
    ln = neg_cnt - gn_q;
    ea = lp + gn_q;
    eb = gp_q + ln;
    sa = {1'b0, gp_q} + {1'b0, ln};
    sb = {1'b0, lp} + {1'b0, gn_q};
  end

  always_comb begin
    state_d = state_q;
    idx_d = idx_q;
    k_d = k_q;
    rd_v_d = 1'b0;
    lo_d = lo_q;
    hi_d = hi_q;
    t_d = t_q;
    gp_d = gp_q;
    gn_d = gn_q;
    best_t_d = best_t_q;
    best_p_d = best_p_q;
    err_d = err_q;
    done_d = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      SIdle: begin
        if (cmd_i.start) begin
          state_d = SScan;
          idx_d = '0;
          lo_d = '0;
          hi_d = '0;
        end
      end
      SScan: begin
        if (rd_v_q) begin
          if (idx_q == CountW'(1) || rd_val_q < lo_q) lo_d = rd_val_q;
          if (idx_q == CountW'(1) || rd_val_q > hi_q) hi_d = rd_val_q;
        end
        if (idx_q < n_q) begin
          idx_d = idx_q + CountW'(1);
          rd_v_d = 1'b1;
        end else if (!rd_v_q) begin
          best_t_d = lo_q;
          if (pos_q > neg_cnt) begin
            best_p_d = 1'b1;
            err_d = neg_cnt;
          end else begin
            best_p_d = 1'b0;
            err_d = pos_q;
          end
          if (hi_q != lo_q) begin
            div_start = 1'b1;
            state_d = SDiv;
          end else begin
            state_d = SDone;
          end
        end
      end
      SDiv: begin
        if (div_done) begin
          t_d = 34'(lo_q) + 34'($signed({1'b0, div_quo}));
          k_d = '0;
          idx_d = '0;
          gp_d = '0;
          gn_d = '0;
          state_d = SCnt;
        end
      end
      SCnt: begin
        if (rd_v_q && (34'(rd_val_q) > t_q)) begin
          if (rd_lbl_q) gp_d = gp_q + CountW'(1);
          else gn_d = gn_q + CountW'(1);
        end
        if (idx_q < n_q) begin
          idx_d = idx_q + CountW'(1);
          rd_v_d = 1'b1;
        end else if (!rd_v_q) begin
          state_d = SEval;
        end
      end
      SEval: begin
        if (sa > sb) begin
          if (ea < err_q) begin
            best_t_d = t_q[31:0];
            best_p_d = 1'b1;
            err_d = ea;
          end
        end else if (eb < err_q) begin
          best_t_d = t_q[31:0];
          best_p_d = 1'b0;
          err_d = eb;
        end
        gp_d = '0;
        gn_d = '0;
        idx_d = '0;
        t_d = t_q + 34'($signed({1'b0, step_q}));
        k_d = k_q + 16'd1;
        if (k_q + 16'd1 >= it_q) state_d = SDone;
        else state_d = SCnt;
      end
      SDone: begin
        done_d = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      rd_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q <= rd_v_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SIdle && cmd_i.start) begin
      n_q <= cmd_i.count;
      pos_q <= cmd_i.positives;
      it_q <= (cmd_i.iter_cnt == 16'd0) ? 16'd1 : cmd_i.iter_cnt;
    end
    if (state_q == SDiv && div_done) step_q <= div_quo;
    idx_q <= idx_d;
    k_q <= k_d;
    lo_q <= lo_d;
    hi_q <= hi_d;
    t_q <= t_d;
    gp_q <= gp_d;
    gn_q <= gn_d;
    best_t_q <= best_t_d;
    best_p_q <= best_p_d;
    err_q <= err_d;
  end

  assign res_o.done = done_q;
  assign res_o.threshold = best_t_q;
  assign res_o.polarity = best_p_q;
  assign res_o.error = err_q;

endmodule

### src/decision_stump_trainer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decision_stump_trainer: sparse decision stump trainer and predictor
// channel  dir  handshake      payload
// in       in   valid/stall    in_item_t
// out      out  valid/stall    out_item_t
// cfg      in   valid/ready    index, data
// feature entries are taken back to back unless stalled; a prediction result
// waits in the output register. end of set runs a min/max scan of the store
// and, if min and max differ, a divide and one store pass per threshold.
// input stalls while the sweep runs or a result is waiting
// reset clears the counts, the drop flag and the learned stump
// ----------------------------------------------------------------------------
module decision_stump_trainer import dst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [19:0] split_q;
  logic [15:0] iter_q;
  logic [CountW-1:0] cnt_q, pos_q;
  logic signed [31:0] cur_q, thr_q;
  logic found_q, pol_q, drop_q, busy_q, ov_q;
  out_item_t out_q;
  logic out_v_q;
  sweep_cmd_t cmd;
  sweep_res_t res;
  logic acc, hit, close_tr;
  logic signed [31:0] v;

  assign acc = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q || out_v_q;
  assign cfg_ready_o = 1'b1;
  assign hit = in_data_i.feature_index == split_q && !found_q;
  assign v = hit ? in_data_i.feature_value : (found_q ? cur_q : 32'sd0);
  assign close_tr = acc && !in_data_i.action &&
                    (in_data_i.end_of_example || in_data_i.end_of_set);

  assign cmd.start = acc && !in_data_i.action && in_data_i.end_of_set;
  assign cmd.count = cnt_q + CountW'(close_tr && cnt_q < CountW'(MaxExamples));
  assign cmd.positives = pos_q + CountW'(close_tr && cnt_q < CountW'(MaxExamples)
                                         && in_data_i.label);
  assign cmd.iter_cnt = iter_q;

  dst_sweep u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (close_tr && cnt_q < CountW'(MaxExamples)),
    .wr_addr_i (cnt_q[AddrW-1:0]),
    .wr_value_i(v),
    .wr_label_i(in_data_i.label),
    .cmd_i     (cmd),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      split_q <= '0;
      iter_q <= 16'd10;
      cnt_q <= '0;
      pos_q <= '0;
      cur_q <= '0;
      found_q <= 1'b0;
      thr_q <= '0;
      pol_q <= 1'b0;
      drop_q <= 1'b0;
      ov_q <= 1'b0;
      busy_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == RegSplitDim) split_q <= cfg_data_i[19:0];
        else iter_q <= cfg_data_i[15:0];
      end
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      if (acc) begin
        if (hit) begin
          cur_q <= in_data_i.feature_value;
          found_q <= 1'b1;
        end
        if (in_data_i.action && in_data_i.end_of_example) begin
          cur_q <= '0;
          found_q <= 1'b0;
          out_v_q <= 1'b1;
          out_q.result_kind <= 1'b1;
          out_q.predicted_label <= (v > thr_q) ? pol_q : !pol_q;
          out_q.threshold <= thr_q;
          out_q.polarity <= pol_q;
          out_q.error_count <= '0;
          out_q.overflow <= 1'b0;
        end
        if (close_tr) begin
          cur_q <= '0;
          found_q <= 1'b0;
          if (cnt_q < CountW'(MaxExamples)) begin
            cnt_q <= cnt_q + CountW'(1);
            if (in_data_i.label) pos_q <= pos_q + CountW'(1);
          end
        end
        if (cmd.start) begin
          busy_q <= 1'b1;
          ov_q <= drop_q || (cnt_q == CountW'(MaxExamples));
        end else if (close_tr && cnt_q == CountW'(MaxExamples)) begin
          drop_q <= 1'b1;
        end
      end
      if (res.done) begin
        busy_q <= 1'b0;
        thr_q <= res.threshold;
        pol_q <= res.polarity;
        cnt_q <= '0;
        pos_q <= '0;
        drop_q <= 1'b0;
        out_v_q <= 1'b1;
        out_q.result_kind <= 1'b0;
        out_q.predicted_label <= 1'b0;
        out_q.threshold <= res.threshold;
        out_q.polarity <= res.polarity;
        out_q.error_count <= 11'(res.error);
        out_q.overflow <= ov_q;
      end
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o = out_q;

endmodule

### src/dst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_checker: port level checks of the decision stump trainer
// result and stall behaviour seen at the top level ports
// ----------------------------------------------------------------------------
module dst_checker import dst_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  a_stall_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while result waits");

  a_pred: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.action && in_data_i.end_of_example
    |=> out_valid_o && out_data_o.result_kind)
    else $error("prediction transfer gave no result");

  a_train: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.action && in_data_i.end_of_set
    |=> in_stall_o)
    else $error("sweep did not stall input");

endmodule

bind decision_stump_trainer dst_checker u_dst_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_data_o (out_data_o)
);

### test/tb_decision_stump_trainer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decision_stump_trainer: self-checking bench of the decision stump trainer
// feature entries are sent with random gaps and the results are received under
// random stalls; each result is compared with the bench's own stump model
// ----------------------------------------------------------------------------
module tb_decision_stump_trainer;
  import dst_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  decision_stump_trainer uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // stump model state
  logic [19:0]        m_split;
  logic [15:0]        m_iter;
  logic signed [31:0] m_vals [MaxExamples];
  logic               m_labs [MaxExamples];
  int unsigned        m_count;
  int unsigned        m_pos;
  logic signed [31:0] m_cur;
  logic               m_found;
  logic signed [31:0] m_thr;
  logic               m_pol;
  logic               m_drop;

  out_item_t   expected_q[$];
  int          errors;
  int          mismatches;
  int          idle_cycles;
  int          hold_left;
  int          rx_wait = 0;

  task automatic sweep_stump(output logic [10:0] err_o);
    longint lo, hi, step, t;
    int unsigned err, it, gp, gn, lp, ln, e;
    logic p;
    lo = 0;
    hi = 0;
    for (int i = 0; i < m_count; i++) begin
      if (i == 0 || m_vals[i] < lo) lo = m_vals[i];
      if (i == 0 || m_vals[i] > hi) hi = m_vals[i];
    end
    m_thr = lo[31:0];
    if (m_pos > m_count - m_pos) begin
      m_pol = 1'b1;
      err = m_count - m_pos;
    end else begin
      m_pol = 1'b0;
      err = m_pos;
    end
    if (hi != lo) begin
      it = (m_iter == 0) ? 1 : m_iter;
      step = (hi - lo) / longint'(it);
      t = lo;
      for (int k = 0; k < it; k++) begin
        gp = 0; gn = 0; lp = 0; ln = 0;
        t += step;
        for (int i = 0; i < m_count; i++) begin
          if (longint'(m_vals[i]) > t) begin
            if (m_labs[i]) gp++; else gn++;
          end else begin
            if (m_labs[i]) lp++; else ln++;
          end
        end
        if (gp + ln > lp + gn) begin
          p = 1'b1;
          e = lp + gn;
        end else begin
          p = 1'b0;
          e = gp + ln;
        end
        if (e < err) begin
          m_thr = t[31:0];
          m_pol = p;
          err = e;
        end
      end
    end
    err_o = err[10:0];
  endtask

  task automatic predict_entry(input in_item_t it);
    out_item_t r;
    logic signed [31:0] v;
    logic [10:0] e;
    if (it.feature_index == m_split && !m_found) begin
      m_cur = it.feature_value;
      m_found = 1'b1;
    end
    if (it.action) begin
      if (!it.end_of_example) return;
      v = m_found ? m_cur : 32'sd0;
      m_cur = 0;
      m_found = 1'b0;
      r = '0;
      r.result_kind = 1'b1;
      r.predicted_label = (v > m_thr) ? m_pol : !m_pol;
      r.threshold = m_thr;
      r.polarity = m_pol;
      expected_q.push_back(r);
      return;
    end
    if (it.end_of_example || it.end_of_set) begin
      v = m_found ? m_cur : 32'sd0;
      m_cur = 0;
      m_found = 1'b0;
      if (m_count < MaxExamples) begin
        m_vals[m_count] = v;
        m_labs[m_count] = it.label;
        m_count++;
        if (it.label) m_pos++;
      end else begin
        m_drop = 1'b1;
      end
    end
    if (!it.end_of_set) return;
    sweep_stump(e);
    r = '0;
    r.threshold = m_thr;
    r.polarity = m_pol;
    r.error_count = e;
    r.overflow = m_drop;
    expected_q.push_back(r);
    m_count = 0;
    m_pos = 0;
    m_drop = 1'b0;
  endtask

  task automatic send_entry(input in_item_t it);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_entry(it);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegSplitDim) m_split = data[19:0];
    else m_iter = data[15:0];
    @(posedge clk);
  endtask

  function automatic in_item_t mk(input logic act, input logic [19:0] idx,
                                  input logic [31:0] val, input logic lab,
                                  input logic eoe, input logic eos);
    in_item_t it;
    it.action = act;
    it.feature_index = idx;
    it.feature_value = val;
    it.label = lab;
    it.end_of_example = eoe;
    it.end_of_set = eos;
    return it;
  endfunction

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(0, 20) << 16;
      default: return $urandom();
    endcase
  endfunction

  // one example of random entries, the split index among them most of the time
  task automatic send_example(input logic act, input logic last);
    int n;
    logic [19:0] idx;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++) begin
      idx = ($urandom_range(0, 2) != 0) ? m_split : 20'($urandom());
      send_entry(mk(act, idx, rand_value(), 1'($urandom_range(0, 1)), i == n - 1,
                    last && i == n - 1));
    end
  endtask

  task automatic send_set(input int n_ex);
    for (int i = 0; i < n_ex; i++) send_example(1'b0, i == n_ex - 1);
  endtask

  task automatic test_directed();
    write_reg(RegNumIter, 32'd0);
    send_entry(mk(1'b0, 20'd0, 32'd0, 1'b0, 1'b0, 1'b1));
    send_entry(mk(1'b1, 20'd0, 32'h8000_0000, 1'b0, 1'b1, 1'b0));
    wait_drained();
    write_reg(RegSplitDim, 32'h000f_ffff);
    write_reg(RegNumIter, 32'd1);
    send_entry(mk(1'b0, 20'hfffff, 32'h8000_0000, 1'b1, 1'b1, 1'b0));
    send_entry(mk(1'b0, 20'hfffff, 32'h7fff_ffff, 1'b0, 1'b0, 1'b0));
    send_entry(mk(1'b0, 20'hfffff, 32'h0001_0000, 1'b1, 1'b1, 1'b0));
    send_entry(mk(1'b1, 20'h00000, 32'h0000_0005, 1'b0, 1'b1, 1'b0));
    send_entry(mk(1'b1, 20'hfffff, 32'h0000_0005, 1'b1, 1'b0, 1'b0));
    send_entry(mk(1'b0, 20'hfffff, 32'h0000_0003, 1'b0, 1'b0, 1'b1));
    send_entry(mk(1'b1, 20'hfffff, 32'h7fff_ffff, 1'b0, 1'b1, 1'b1));
    send_entry(mk(1'b1, 20'h12345, 32'h7fff_ffff, 1'b1, 1'b1, 1'b0));
    send_entry(mk(1'b1, 20'hfffff, 32'h8000_0000, 1'b0, 1'b0, 1'b0));
    send_entry(mk(1'b0, 20'hfffff, 32'h7fff_ffff, 1'b1, 1'b1, 1'b0));
    send_entry(mk(1'b0, 20'hfffff, 32'hffff_0000, 1'b0, 1'b1, 1'b1));
    send_entry(mk(1'b1, 20'hfffff, 32'h0000_0000, 1'b0, 1'b1, 1'b0));
    wait_drained();
  endtask

  task automatic test_capacity();
    write_reg(RegNumIter, 32'd2);
    write_reg(RegSplitDim, 32'd7);
    for (int i = 0; i < MaxExamples + 3; i++)
      send_entry(mk(1'b0, 20'd7, $urandom(), 1'($urandom_range(0, 1)), 1'b1,
                    i == MaxExamples + 2));
    wait_drained();
  endtask

  task automatic test_backpressure();
    write_reg(RegNumIter, 32'd4);
    hold_left = 200;
    for (int i = 0; i < 6; i++) send_example(1'b1, 1'b0);
    wait_drained();
  endtask

  task automatic test_random();
    for (int s = 0; s < 2; s++) begin
      write_reg(RegSplitDim, $urandom_range(0, 1) ? 32'($urandom_range(0, 3))
                                                  : 32'($urandom()));
      write_reg(RegNumIter, $urandom_range(0, 3) == 0 ? 32'hffff
                                                     : 32'($urandom_range(0, 12)));
      for (int b = 0; b < 2; b++) begin
        if (m_iter > 1000) send_set($urandom_range(1, 3));
        else send_set($urandom_range(1, 12));
        for (int p = 0; p < 5; p++) send_example(1'b1, 1'b0);
        if ($urandom_range(0, 3) == 0)
          send_entry(mk(1'b1, 20'($urandom()), $urandom(), 1'b0, 1'b0, 1'b1));
      end
      wait_drained();
    end
  endtask

  // receiver: a drawn wait after each transfer, or a long hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      if (out_valid && !out_stall) rx_wait = $urandom_range(0, 10);
      else if (rx_wait > 0) rx_wait = rx_wait - 1;
      out_stall <= (rx_wait != 0);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        errors++;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (out_data.result_kind !== exp_r.result_kind
            || out_data.predicted_label !== exp_r.predicted_label
            || out_data.threshold !== exp_r.threshold
            || out_data.polarity !== exp_r.polarity
            || out_data.error_count !== exp_r.error_count
            || out_data.overflow !== exp_r.overflow) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_r, out_data);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)
        || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    errors = 0;
    mismatches = 0;
    idle_cycles = 0;
    hold_left = 0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegSplitDim;
    cfg_data = '0;
    m_split = '0;
    m_iter = 16'd10;
    m_count = 0;
    m_pos = 0;
    m_cur = 0;
    m_found = 1'b0;
    m_thr = 0;
    m_pol = 1'b0;
    m_drop = 1'b0;
    rst_n = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity();
    test_backpressure();
    test_random();
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
